FILE: hw/rtl/lfr_pkg.sv
// Package for the LIN frame receiver: transaction structs, operation, status and
// phase codes, protected-identifier parity and end-around-carry add.
// No dependencies.
package lfr_pkg;

  localparam int unsigned MaxDataBytes = 8;
  localparam logic [7:0]  SyncByte     = 8'h55;
  localparam logic [15:0] TimeoutReset = 16'd100;
  localparam logic [5:0]  IdLastShort  = 6'h1F;
  localparam logic [5:0]  IdLastMid    = 6'h2F;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_BREAK = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } lfr_op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CHECKSUM = 3'd1,
    ST_SYNC     = 3'd2,
    ST_PID      = 3'd3,
    ST_TIMEOUT  = 3'd4
  } lfr_status_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SYNC = 2'd1,
    PH_PID  = 2'd2,
    PH_DATA = 2'd3
  } lfr_phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } lfr_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  frame_id;
    logic [3:0]  data_length;
    logic [63:0] frame_data;
    logic [7:0]  received_checksum;
    logic [31:0] timestamp;
    logic [7:0]  error_total;
    logic [31:0] good_frames;
  } lfr_out_t;

  // Check both parity bits of a protected identifier against its six ID bits.
  function automatic logic pid_parity_ok(input logic [7:0] pid);
    logic p0;
    logic p1;
    p0 = pid[0] ^ pid[1] ^ pid[2] ^ pid[4];
    p1 = ~(pid[1] ^ pid[3] ^ pid[4] ^ pid[5]);
    return {p1, p0, pid[5:0]} == pid;
  endfunction

  // Eight-bit add with the carry folded back into bit 0.
  function automatic logic [7:0] add_carry(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

FILE: hw/rtl/lfr_frame.sv
// Frame tracking for the LIN frame receiver: phase machine, counters and
// frame assembly; produces at most one result per accepted transaction.
// Depends on lfr_pkg.
module lfr_frame (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  lfr_pkg::lfr_in_t item,
  input  logic [15:0]      timeout_ticks,
  output logic             fire,
  output lfr_pkg::lfr_out_t res
);
  import lfr_pkg::*;

  lfr_phase_t  phase, phase_next;
  logic [3:0]  byte_pos, byte_pos_next;
  logic [3:0]  exp_bytes, exp_bytes_next;
  logic [7:0]  pid, pid_next;
  logic [63:0] data_asm, data_asm_next;
  logic [7:0]  run_sum, run_sum_next;
  logic [15:0] quiet, quiet_next;
  logic [31:0] tick_cnt, tick_cnt_next;
  logic [7:0]  err_cnt, err_cnt_next;
  logic [31:0] frame_cnt, frame_cnt_next;

  lfr_op_t     op;
  logic [7:0]  b;
  logic [15:0] quiet_inc;
  logic        timeout_hit;
  logic        parity_good;
  logic        pos_more;
  logic [7:0]  err_inc;

  assign op          = lfr_op_t'(item.operation);
  assign b           = item.rx_byte;
  assign quiet_inc   = (quiet == 16'hFFFF) ? quiet : quiet + 16'd1;
  assign timeout_hit = quiet_inc > timeout_ticks;
  assign parity_good = pid_parity_ok(b);
  assign pos_more    = byte_pos < exp_bytes;
  assign err_inc     = (err_cnt == 8'hFF) ? err_cnt : err_cnt + 8'd1;

  // Next phase
  always_comb begin
    phase_next = phase;
    case (op)
      OP_BREAK: phase_next = PH_SYNC;
      OP_TICK: begin
        if (phase != PH_IDLE && timeout_hit) phase_next = PH_IDLE;
      end
      OP_BYTE: begin
        case (phase)
          PH_SYNC: phase_next = (b == SyncByte) ? PH_PID : PH_IDLE;
          PH_PID:  phase_next = parity_good ? PH_DATA : PH_IDLE;
          PH_DATA: phase_next = pos_more ? PH_DATA : PH_IDLE;
          default: phase_next = phase;
        endcase
      end
      default: phase_next = phase;
    endcase
  end

  // Datapath updates and result
  always_comb begin
    byte_pos_next  = byte_pos;
    exp_bytes_next = exp_bytes;
    pid_next       = pid;
    data_asm_next  = data_asm;
    run_sum_next   = run_sum;
    quiet_next     = quiet;
    tick_cnt_next  = tick_cnt;
    err_cnt_next   = err_cnt;
    frame_cnt_next = frame_cnt;
    fire           = 1'b0;
    res            = '0;
    case (op)
      OP_BREAK: begin
        byte_pos_next = 4'd0;
        quiet_next    = 16'd0;
        data_asm_next = '0;
        run_sum_next  = 8'd0;
      end
      OP_TICK: begin
        tick_cnt_next = tick_cnt + 32'd1;
        if (phase != PH_IDLE) begin
          quiet_next = quiet_inc;
          if (timeout_hit) begin
            fire         = 1'b1;
            err_cnt_next = err_inc;
            res.status   = ST_TIMEOUT;
            res.frame_id = (phase == PH_DATA) ? pid[5:0] : 6'd0;
          end
        end
      end
      OP_BYTE: begin
        quiet_next = 16'd0;
        case (phase)
          PH_SYNC: begin
            if (b != SyncByte) begin
              fire         = 1'b1;
              err_cnt_next = err_inc;
              res.status   = ST_SYNC;
            end
          end
          PH_PID: begin
            if (!parity_good) begin
              fire         = 1'b1;
              err_cnt_next = err_inc;
              res.status   = ST_PID;
              res.frame_id = b[5:0];
            end else begin
              pid_next      = b;
              byte_pos_next = 4'd0;
              data_asm_next = '0;
              run_sum_next  = b;
              if (b[5:0] <= IdLastShort)    exp_bytes_next = 4'd2;
              else if (b[5:0] <= IdLastMid) exp_bytes_next = 4'd4;
              else                          exp_bytes_next = 4'(MaxDataBytes);
            end
          end
          PH_DATA: begin
            if (pos_more) begin
              for (int i = 0; i < MaxDataBytes; i++) begin
                if (byte_pos[2:0] == 3'(i)) data_asm_next[i*8 +: 8] = data_asm[i*8 +: 8] | b;
              end
              run_sum_next  = add_carry(run_sum, b);
              byte_pos_next = byte_pos + 4'd1;
            end else begin
              fire                  = 1'b1;
              res.frame_id          = pid[5:0];
              res.data_length       = exp_bytes;
              res.frame_data        = data_asm;
              res.received_checksum = b;
              if (~run_sum == b) begin
                res.status     = ST_OK;
                frame_cnt_next = frame_cnt + 32'd1;
              end else begin
                res.status   = ST_CHECKSUM;
                err_cnt_next = err_inc;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    res.timestamp   = tick_cnt_next;
    res.error_total = err_cnt_next;
    res.good_frames = frame_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      byte_pos  <= 4'd0;
      exp_bytes <= 4'd0;
      pid       <= 8'd0;
      data_asm  <= '0;
      run_sum   <= 8'd0;
      quiet     <= 16'd0;
      tick_cnt  <= 32'd0;
      err_cnt   <= 8'd0;
      frame_cnt <= 32'd0;
    end else if (take) begin
      phase     <= phase_next;
      byte_pos  <= byte_pos_next;
      exp_bytes <= exp_bytes_next;
      pid       <= pid_next;
      data_asm  <= data_asm_next;
      run_sum   <= run_sum_next;
      quiet     <= quiet_next;
      tick_cnt  <= tick_cnt_next;
      err_cnt   <= err_cnt_next;
      frame_cnt <= frame_cnt_next;
    end
  end

endmodule

FILE: hw/rtl/lin_frame_receiver.sv
// Top level of the LIN frame receiver: timeout register, frame tracking and
// the result register. Depends on lfr_pkg and lfr_frame.
//
//   channel   direction  handshake                   payload
//   item      in         item_valid / item_stall     lfr_in_t  (operation, rx_byte)
//   result    out        result_valid / result_stall lfr_out_t (status ... good_frames)
//   cfg       in         cfg_wr_en                   cfg_wr_data (timeout_ticks)
//
// One transaction is taken per cycle unless the item side stalls; its result,
// if any, appears in the result register in the cycle after acceptance, set
// by the single compare/add pass in lfr_frame. Synchronous reset clears the
// phase, all counters and the result valid, and loads the timeout with 100
// ticks. A stalled result holds the register; the item side stalls only while
// that register is full and stalled, so a draining result never stalls items.
module lin_frame_receiver (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  lfr_pkg::lfr_in_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output lfr_pkg::lfr_out_t result,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data
);
  import lfr_pkg::*;

  logic [15:0] timeout_ticks;
  logic        take;
  logic        fire;
  lfr_out_t    res;

  // Hold new items only while a finished result is waiting and stalled.
  assign item_stall = result_valid & result_stall;
  assign take       = item_valid & ~item_stall;

  // Timeout register: load on every write enable; there is no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TimeoutReset;
    end else if (cfg_wr_en) begin
      timeout_ticks <= cfg_wr_data;
    end
  end

  lfr_frame u_frame (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .item          (item),
    .timeout_ticks (timeout_ticks),
    .fire          (fire),
    .res           (res)
  );

  // Result valid: load on a producing transaction, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take && fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload: advance only when a new result arrives.
  always_ff @(posedge clk) begin
    if (take && fire) begin
      result <= res;
    end
  end

endmodule
